// ----- src/circle_segment_intersect_macros.svh -----
// Assertion macros for the circle/segment intersection block.
// Used by the top level; relies on clk and rst being in scope.
`ifndef CIRCLE_SEGMENT_INTERSECT_MACROS_SVH
`define CIRCLE_SEGMENT_INTERSECT_MACROS_SVH
`ifndef SYNTHESIS
`define CSI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circle_segment_intersect: same-cycle check failed");
`define CSI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circle_segment_intersect: next-cycle check failed");
`else
`define CSI_ASSERT_IMP(lbl, ante, cons)
`define CSI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- src/csi_pkg.sv -----
// Shared widths and beat types for the circle/segment intersection block.
// No dependencies; the modules refer to it by scoped names.
package csi_pkg;

  localparam int COORD_BITS = 32;
  localparam int RAD_BITS   = COORD_BITS - 1;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int A_BITS     = 2 * COORD_BITS + 1;
  localparam int B_BITS     = 2 * COORD_BITS + 2;
  localparam int R2_BITS    = 2 * RAD_BITS;

  localparam int MUL_W      = A_BITS + 1;
  localparam int MUL_CHUNKS = 3;
  localparam int MUL_CHUNK  = (MUL_W + MUL_CHUNKS - 1) / MUL_CHUNKS;
  localparam int MUL_LAT    = 3;

  localparam int DISC_BITS  = 2 * MUL_W + 1;
  localparam int SQ_IN_BITS = 4 * COORD_BITS;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int N_BITS     = B_BITS + 1;

  localparam int NUM_BITS   = 3 * COORD_BITS + 4;
  localparam int DEN_BITS   = A_BITS + 1;
  localparam int QUO_BITS   = COORD_BITS + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] centre_x;
    logic signed [COORD_BITS-1:0] centre_y;
    logic [RAD_BITS-1:0]          circle_radius;
  } query_t;

  typedef struct packed {
    logic [1:0]                   hit_count;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
  } result_t;

endpackage

// ----- src/csi_mul.sv -----
// Pipelined unsigned multiplier built from narrow partial products.
// Three register stages; depends on csi_pkg.
module csi_mul (
  input  logic                          clk,
  input  logic                          en,
  input  logic [csi_pkg::MUL_W-1:0]     a,
  input  logic [csi_pkg::MUL_W-1:0]     b,
  output logic [2*csi_pkg::MUL_W-1:0]   p
);

  localparam int C   = csi_pkg::MUL_CHUNK;
  localparam int N   = csi_pkg::MUL_CHUNKS;
  localparam int PADW = N * C;
  localparam int PW  = 2 * csi_pkg::MUL_W;
  localparam int SW  = 2 * PADW;

  logic [PADW-1:0] a_pad, b_pad;
  logic [2*C-1:0]  pp      [0:N-1][0:N-1];
  logic [SW-1:0]   row     [0:N-1];
  logic [SW-1:0]   row_sum [0:N-1];
  logic [SW-1:0]   total;

  assign a_pad = PADW'(a);
  assign b_pad = PADW'(b);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      row_sum[i] = '0;
      for (int j = 0; j < N; j++) begin
        row_sum[i] = row_sum[i] + (SW'(pp[i][j]) << ((i + j) * C));
      end
    end
    total = '0;
    for (int i = 0; i < N; i++) begin
      total = total + row[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < N; j++) begin
          pp[i][j] <= a_pad[i*C +: C] * b_pad[j*C +: C];
        end
        row[i] <= row_sum[i];
      end
      p <= total[PW-1:0];
    end
  end

endmodule

// ----- src/csi_sqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Gives floor(sqrt(radicand)); depends on csi_pkg.
module csi_sqrt (
  input  logic                              clk,
  input  logic                              en,
  input  logic [csi_pkg::SQ_IN_BITS-1:0]    radicand,
  output logic [csi_pkg::SQ_BITS-1:0]       root
);

  localparam int STAGES = csi_pkg::SQ_BITS;
  localparam int IW     = csi_pkg::SQ_IN_BITS;
  localparam int RW     = csi_pkg::SQ_BITS;
  localparam int REM_W  = csi_pkg::SQ_BITS + 3;

  logic [REM_W-1:0] rem_q  [0:STAGES-1];
  logic [RW-1:0]    root_q [0:STAGES-1];
  logic [IW-1:0]    rad_q  [0:STAGES-1];

  genvar k;
  for (k = 0; k < STAGES; k++) begin : g_stage
    logic [REM_W-1:0] rem_prev, rem_sh, trial;
    logic [RW-1:0]    root_prev;
    logic [IW-1:0]    rad_prev;

    if (k == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign rad_prev  = radicand;
    end else begin : g_next
      assign rem_prev  = rem_q[k-1];
      assign root_prev = root_q[k-1];
      assign rad_prev  = rad_q[k-1];
    end

    // The remainder never exceeds twice the partial root, so its top two bits are free.
    assign rem_sh = {rem_prev[REM_W-3:0], rad_prev[IW-1 -: 2]};
    assign trial  = {1'b0, root_prev, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_q[k]  <= rem_sh - trial;
          root_q[k] <= {root_prev[RW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh;
          root_q[k] <= {root_prev[RW-2:0], 1'b0};
        end
        rad_q[k] <= rad_prev << 2;
      end
    end
  end

  assign root = root_q[STAGES-1];

endmodule

// ----- src/csi_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient must fit in QUO_BITS; depends on csi_pkg.
module csi_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic [csi_pkg::NUM_BITS-1:0]    num,
  input  logic [csi_pkg::DEN_BITS-1:0]    den,
  output logic [csi_pkg::QUO_BITS-1:0]    quo
);

  localparam int STAGES = csi_pkg::QUO_BITS;
  localparam int NW     = csi_pkg::NUM_BITS;
  localparam int DW     = csi_pkg::DEN_BITS;
  localparam int QW     = csi_pkg::QUO_BITS;

  logic [NW-1:0] rem_q [0:STAGES-1];
  logic [DW-1:0] den_q [0:STAGES-1];
  logic [QW-1:0] quo_q [0:STAGES-1];

  genvar k;
  for (k = 0; k < STAGES; k++) begin : g_stage
    localparam int BIT = STAGES - 1 - k;
    logic [NW-1:0] rem_prev, shifted;
    logic [DW-1:0] den_prev;
    logic [QW-1:0] quo_prev;

    if (k == 0) begin : g_first
      assign rem_prev = num;
      assign den_prev = den;
      assign quo_prev = '0;
    end else begin : g_next
      assign rem_prev = rem_q[k-1];
      assign den_prev = den_q[k-1];
      assign quo_prev = quo_q[k-1];
    end

    assign shifted = NW'(den_prev) << BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[k] <= den_prev;
        if (rem_prev >= shifted) begin
          rem_q[k] <= rem_prev - shifted;
          quo_q[k] <= quo_prev | (QW'(1) << BIT);
        end else begin
          rem_q[k] <= rem_prev;
          quo_q[k] <= quo_prev;
        end
      end
    end
  end

  assign quo = quo_q[STAGES-1];

endmodule

// ----- src/circle_segment_intersect.sv -----
// Segment/circle intersection, fully pipelined; top level of the block.
// Depends on csi_pkg, csi_mul, csi_sqrt, csi_div and the assertion macro header.
//
//   channel  | valid         | stall         | beat
//   ---------+---------------+---------------+---------------------------
//   query    | query_valid   | query_stall   | query  (csi_pkg::query_t)
//   result   | result_valid  | result_stall  | result (csi_pkg::result_t)
//
// One query enters per cycle while query_stall is low; each result is offered
// after its query is accepted and has passed through 112 register stages.
// The depth is dominated by the 64-stage square root and the 33-stage dividers.
// The whole pipeline advances together; it halts only while the output beat
// is held by result_stall, and query_stall follows that condition directly.
// Synchronous reset clears every valid bit; nothing else needs clearing.
`include "circle_segment_intersect_macros.svh"
module circle_segment_intersect (
  input  logic               clk,
  input  logic               rst,
  input  logic               query_valid,
  output logic               query_stall,
  input  csi_pkg::query_t    query,
  output logic               result_valid,
  input  logic               result_stall,
  output csi_pkg::result_t   result
);

  localparam int CB   = csi_pkg::COORD_BITS;
  localparam int DB   = csi_pkg::DIFF_BITS;
  localparam int PB   = csi_pkg::PROD_BITS;
  localparam int AB   = csi_pkg::A_BITS;
  localparam int BB   = csi_pkg::B_BITS;
  localparam int RB   = csi_pkg::RAD_BITS;
  localparam int R2B  = csi_pkg::R2_BITS;
  localparam int MW   = csi_pkg::MUL_W;
  localparam int ML   = csi_pkg::MUL_LAT;
  localparam int DSB  = csi_pkg::DISC_BITS;
  localparam int SIB  = csi_pkg::SQ_IN_BITS;
  localparam int SB   = csi_pkg::SQ_BITS;
  localparam int NB   = csi_pkg::N_BITS;
  localparam int NUMB = csi_pkg::NUM_BITS;
  localparam int DENB = csi_pkg::DEN_BITS;
  localparam int QB   = csi_pkg::QUO_BITS;

  localparam logic signed [CB+1:0] V_MAX = {3'b000, {(CB-1){1'b1}}};
  localparam logic signed [CB+1:0] V_MIN = {3'b111, {(CB-1){1'b0}}};

  typedef struct packed {
    logic                 v;
    logic                 az;
    logic                 dneg;
    logic                 dzero;
    logic [AB-1:0]        a;
    logic signed [BB-1:0] b;
    logic signed [CB-1:0] sx;
    logic signed [CB-1:0] sy;
    logic signed [DB-1:0] dx;
    logic signed [DB-1:0] dy;
  } geo_t;

  typedef struct packed {
    logic                 v;
    logic [1:0]           hits;
    logic [AB-1:0]        a;
    logic signed [CB-1:0] sx;
    logic signed [CB-1:0] sy;
    logic                 xneg;
    logic                 yneg;
  } fin_t;

  function automatic logic signed [CB-1:0] place(input logic signed [CB-1:0] s,
                                                 input logic neg,
                                                 input logic [QB-1:0] q);
    logic signed [CB+1:0] s_ext;
    logic signed [CB+1:0] q_ext;
    logic signed [CB+1:0] v;
    s_ext = (CB+2)'(s);
    q_ext = $signed((CB+2)'(q));
    v = neg ? s_ext - q_ext : s_ext + q_ext;
    if (v > V_MAX) begin
      place = {1'b0, {(CB-1){1'b1}}};
    end else if (v < V_MIN) begin
      place = {1'b1, {(CB-1){1'b0}}};
    end else begin
      place = v[CB-1:0];
    end
  endfunction

  logic adv;

  // Stage 1: differences.
  logic                 v1;
  logic signed [DB-1:0] dx1, dy1, qx1, qy1;
  logic signed [CB-1:0] sx1, sy1;
  logic [RB-1:0]        r1;

  // Stage 2: narrow products.
  logic                 v2;
  logic signed [PB-1:0] pxx, pyy, pxq, pyq, pxc, pyc;
  logic [R2B-1:0]       r2_2;
  logic signed [CB-1:0] sx2, sy2;
  logic signed [DB-1:0] dx2, dy2;

  // Stage 3: dot and cross products.
  geo_t                 g3;
  logic signed [BB-1:0] cr3;
  logic [R2B-1:0]       r2_3;
  logic signed [PB-1:0] sum_a;

  // Stage 4: cross magnitude.
  geo_t                 g4;
  logic [MW-1:0]        crm4;
  logic [R2B-1:0]       r2_4;

  geo_t                 mul_line [0:ML-1];
  logic [2*MW-1:0]      ar2_p, cr2_p;

  // Stage 8: discriminant.
  geo_t                 g8;
  geo_t                 g8_next;
  logic [SIB-1:0]       rad8;
  logic signed [DSB-1:0] disc;

  geo_t                 sq_line [0:SB-1];
  logic [SB-1:0]        sq_root;
  geo_t                 gs;

  // Root numerators.
  geo_t                 g73;
  logic [1:0]           cnt73;
  logic signed [NB-1:0] n0, n1;
  logic signed [NB-1:0] b_ext, s_ext;

  // Root selection.
  fin_t                 f74;
  logic [AB-1:0]        fn74, sn74;
  logic [CB-1:0]        dxm74, dym74;
  logic                 ok0, ok1;

  fin_t                 mul2_line [0:ML-1];
  logic [2*MW-1:0]      pfx, pfy, psx, psy;

  // Division operands.
  fin_t                 f78;
  logic [NUMB-1:0]      num_fx, num_fy, num_sx, num_sy;
  logic [DENB-1:0]      den78;

  fin_t                 div_line [0:QB-1];
  logic [QB-1:0]        qfx, qfy, qsx, qsy;
  fin_t                 fz;

  assign adv         = !(result_valid && result_stall);
  assign query_stall = !adv;

  assign sum_a = pxx + pyy;
  assign disc  = $signed({1'b0, ar2_p}) - $signed({1'b0, cr2_p});
  assign gs    = sq_line[SB-1];
  assign b_ext = NB'(gs.b);
  assign s_ext = $signed(NB'(sq_root));

  assign ok0 = (cnt73 != 2'd0) && !n0[NB-1] && (n0[NB-2:0] <= (NB-1)'(g73.a));
  assign ok1 = (cnt73 == 2'd2) && !n1[NB-1] && (n1[NB-2:0] <= (NB-1)'(g73.a));

  assign fz = div_line[QB-1];

  // The discriminant b*b - a*c equals a*r*r minus the squared cross product.
  always_comb begin
    g8_next       = mul_line[ML-1];
    g8_next.dneg  = disc[DSB-1];
    g8_next.dzero = (disc == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      g3.v   <= 1'b0;
      g4.v   <= 1'b0;
      g8.v   <= 1'b0;
      g73.v  <= 1'b0;
      f74.v  <= 1'b0;
      f78.v  <= 1'b0;
      for (int i = 0; i < ML; i++) begin
        mul_line[i].v  <= 1'b0;
        mul2_line[i].v <= 1'b0;
      end
      for (int i = 0; i < SB; i++) begin
        sq_line[i].v <= 1'b0;
      end
      for (int i = 0; i < QB; i++) begin
        div_line[i].v <= 1'b0;
      end
      result_valid <= 1'b0;
    end else if (adv) begin
      v1  <= query_valid;
      dx1 <= DB'(query.end_x) - DB'(query.start_x);
      dy1 <= DB'(query.end_y) - DB'(query.start_y);
      qx1 <= DB'(query.start_x) - DB'(query.centre_x);
      qy1 <= DB'(query.start_y) - DB'(query.centre_y);
      sx1 <= query.start_x;
      sy1 <= query.start_y;
      r1  <= query.circle_radius;

      v2   <= v1;
      pxx  <= dx1 * dx1;
      pyy  <= dy1 * dy1;
      pxq  <= dx1 * qx1;
      pyq  <= dy1 * qy1;
      pxc  <= dx1 * qy1;
      pyc  <= dy1 * qx1;
      r2_2 <= r1 * r1;
      sx2  <= sx1;
      sy2  <= sy1;
      dx2  <= dx1;
      dy2  <= dy1;

      g3.v     <= v2;
      g3.az    <= (dx2 == '0) && (dy2 == '0);
      g3.dneg  <= 1'b0;
      g3.dzero <= 1'b0;
      g3.a     <= sum_a[AB-1:0];
      g3.b     <= BB'(pxq + pyq);
      g3.sx    <= sx2;
      g3.sy    <= sy2;
      g3.dx    <= dx2;
      g3.dy    <= dy2;
      cr3      <= BB'(pxc - pyc);
      r2_3     <= r2_2;

      g4   <= g3;
      crm4 <= cr3[BB-1] ? MW'(-cr3) : MW'(cr3);
      r2_4 <= r2_3;

      mul_line[0] <= g4;
      for (int i = 1; i < ML; i++) begin
        mul_line[i] <= mul_line[i-1];
      end

      g8   <= g8_next;
      rad8 <= disc[DSB-1] ? '0 : disc[SIB-1:0];

      sq_line[0] <= g8;
      for (int i = 1; i < SB; i++) begin
        sq_line[i] <= sq_line[i-1];
      end

      g73 <= gs;
      n0  <= s_ext - b_ext;
      n1  <= -b_ext - s_ext;
      if (gs.az || gs.dneg) begin
        cnt73 <= 2'd0;
      end else if (gs.dzero) begin
        cnt73 <= 2'd1;
      end else begin
        cnt73 <= 2'd2;
      end

      // When only the second root lies on the segment it is reported first.
      f74.v    <= g73.v;
      f74.hits <= {1'b0, ok0} + {1'b0, ok1};
      f74.a    <= g73.a;
      f74.sx   <= g73.sx;
      f74.sy   <= g73.sy;
      f74.xneg <= g73.dx[DB-1];
      f74.yneg <= g73.dy[DB-1];
      fn74     <= ok0 ? n0[AB-1:0] : n1[AB-1:0];
      sn74     <= n1[AB-1:0];
      dxm74    <= g73.dx[DB-1] ? CB'(-g73.dx) : CB'(g73.dx);
      dym74    <= g73.dy[DB-1] ? CB'(-g73.dy) : CB'(g73.dy);

      mul2_line[0] <= f74;
      for (int i = 1; i < ML; i++) begin
        mul2_line[i] <= mul2_line[i-1];
      end

      // Round to nearest: floor((2*|d|*n + a) / (2*a)).
      f78    <= mul2_line[ML-1];
      num_fx <= {pfx[NUMB-2:0], 1'b0} + NUMB'(mul2_line[ML-1].a);
      num_fy <= {pfy[NUMB-2:0], 1'b0} + NUMB'(mul2_line[ML-1].a);
      num_sx <= {psx[NUMB-2:0], 1'b0} + NUMB'(mul2_line[ML-1].a);
      num_sy <= {psy[NUMB-2:0], 1'b0} + NUMB'(mul2_line[ML-1].a);
      den78  <= {mul2_line[ML-1].a, 1'b0};

      div_line[0] <= f78;
      for (int i = 1; i < QB; i++) begin
        div_line[i] <= div_line[i-1];
      end

      result_valid     <= fz.v;
      result.hit_count <= fz.hits;
      result.first_x   <= (fz.hits != 2'd0) ? place(fz.sx, fz.xneg, qfx) : '0;
      result.first_y   <= (fz.hits != 2'd0) ? place(fz.sy, fz.yneg, qfy) : '0;
      result.second_x  <= (fz.hits == 2'd2) ? place(fz.sx, fz.xneg, qsx) : '0;
      result.second_y  <= (fz.hits == 2'd2) ? place(fz.sy, fz.yneg, qsy) : '0;
    end
  end

  csi_mul u_mul_ar2 (
    .clk (clk),
    .en  (adv),
    .a   (MW'(g4.a)),
    .b   (MW'(r2_4)),
    .p   (ar2_p)
  );

  csi_mul u_mul_cr2 (
    .clk (clk),
    .en  (adv),
    .a   (crm4),
    .b   (crm4),
    .p   (cr2_p)
  );

  csi_sqrt u_sqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (rad8),
    .root     (sq_root)
  );

  csi_mul u_mul_fx (
    .clk (clk),
    .en  (adv),
    .a   (MW'(dxm74)),
    .b   (MW'(fn74)),
    .p   (pfx)
  );

  csi_mul u_mul_fy (
    .clk (clk),
    .en  (adv),
    .a   (MW'(dym74)),
    .b   (MW'(fn74)),
    .p   (pfy)
  );

  csi_mul u_mul_sx (
    .clk (clk),
    .en  (adv),
    .a   (MW'(dxm74)),
    .b   (MW'(sn74)),
    .p   (psx)
  );

  csi_mul u_mul_sy (
    .clk (clk),
    .en  (adv),
    .a   (MW'(dym74)),
    .b   (MW'(sn74)),
    .p   (psy)
  );

  csi_div u_div_fx (
    .clk (clk),
    .en  (adv),
    .num (num_fx),
    .den (den78),
    .quo (qfx)
  );

  csi_div u_div_fy (
    .clk (clk),
    .en  (adv),
    .num (num_fy),
    .den (den78),
    .quo (qfy)
  );

  csi_div u_div_sx (
    .clk (clk),
    .en  (adv),
    .num (num_sx),
    .den (den78),
    .quo (qsx)
  );

  csi_div u_div_sy (
    .clk (clk),
    .en  (adv),
    .num (num_sy),
    .den (den78),
    .quo (qsy)
  );

  `CSI_ASSERT_IMP(a_hits_range, result_valid, result.hit_count != 2'd3)
  `CSI_ASSERT_IMP(a_first_clear, result_valid && result.hit_count == 2'd0, result.first_x == '0 && result.first_y == '0)
  `CSI_ASSERT_IMP(a_second_clear, result_valid && result.hit_count != 2'd2, result.second_x == '0 && result.second_y == '0)
  `CSI_ASSERT_NEXT(a_drain, !result_stall && !fz.v, !result_valid)

endmodule
